/* src/tfgs_pkg.sv */
`default_nettype none
package tfgs_pkg;

    localparam int TIME_W = 40;
    localparam int FREQ_W = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 39;
    localparam int ITER_W = 6;
    localparam int NOTE_LOW = 0;

    localparam logic OP_SNAP = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_NOTE = 2'd1;
    localparam logic [1:0] SRC_HARMONIC = 2'd2;
    localparam logic [1:0] SRC_CUSTOM = 2'd3;

    localparam logic [1:0] TIMING_OFF = 2'd0;
    localparam logic [1:0] TIMING_INTERVAL = 2'd1;
    localparam logic [1:0] TIMING_TEMPO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY_ENABLES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_PITCH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_FUNDAMENTAL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_COUNT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMING_MODE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LENGTH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_FRACTION = 4'd7;

    typedef struct packed {
        logic start;
        logic [ITER_W-1:0] iters;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    function automatic logic [24:0] pow24(input logic [4:0] idx);
        logic [24:0] v;
        case (idx)
            5'd0: v = 25'd16777216;
            5'd1: v = 25'd17268826;
            5'd2: v = 25'd17774841;
            5'd3: v = 25'd18295684;
            5'd4: v = 25'd18831788;
            5'd5: v = 25'd19383602;
            5'd6: v = 25'd19951585;
            5'd7: v = 25'd20536211;
            5'd8: v = 25'd21137968;
            5'd9: v = 25'd21757357;
            5'd10: v = 25'd22394897;
            5'd11: v = 25'd23051117;
            5'd12: v = 25'd23726566;
            5'd13: v = 25'd24421808;
            5'd14: v = 25'd25137421;
            5'd15: v = 25'd25874004;
            5'd16: v = 25'd26632170;
            5'd17: v = 25'd27412552;
            5'd18: v = 25'd28215802;
            5'd19: v = 25'd29042588;
            5'd20: v = 25'd29893600;
            5'd21: v = 25'd30769550;
            5'd22: v = 25'd31671166;
            5'd23: v = 25'd32599202;
            default: v = 25'd16777216;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/time_frequency_grid_snap_unit.sv */
`default_nettype none
// Channel   Direction  Contents
// s_        in         tdata: time_value, frequency_value, entry_index, entry_frequency; tuser: op
// m_        out        tdata: time_out, frequency_out; tuser: frequency_source, time_snapped
// cfg_      in         register index and write data, always ready
// A snap runs the note search on the shared multiplier, the harmonic remainder, a compare
// per custom entry, the tempo step division and the time remainder, in that order. The
// divider is W = FRACTION_BITS + 32 bits wide; every division runs through one shared
// bit-serial divider. s_tready is low while a snap is in progress.
// Reset restores the register defaults; the custom table holds no reset value.
// A finished result waits in the output register while the next item is taken.
module time_frequency_grid_snap_unit #(
    parameter int CUSTOM_DEPTH = 8,
    parameter int NOTE_HIGH = 135,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata, // time_value, frequency_value, entry_index, entry_frequency
    input  wire logic         s_tuser, // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [71:0]  m_tdata, // time_out, frequency_out
    output logic      [2:0]   m_tuser, // frequency_source, time_snapped
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [38:0]  cfg_data
);

    localparam int W = FRACTION_BITS + 32;
    localparam int AW = CUSTOM_DEPTH > 1 ? $clog2(CUSTOM_DEPTH) : 1;
    localparam int CW = $clog2(CUSTOM_DEPTH + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NOTE_A = 4'd1;
    localparam logic [3:0] ST_NOTE_B = 4'd2;
    localparam logic [3:0] ST_CAND_A = 4'd3;
    localparam logic [3:0] ST_CAND_B = 4'd4;
    localparam logic [3:0] ST_HARM_CHK = 4'd5;
    localparam logic [3:0] ST_HARM_WAIT = 4'd6;
    localparam logic [3:0] ST_CUST_CHK = 4'd7;
    localparam logic [3:0] ST_CUST_RD = 4'd8;
    localparam logic [3:0] ST_CUST_CMP = 4'd9;
    localparam logic [3:0] ST_TEMPO_CHK = 4'd10;
    localparam logic [3:0] ST_TEMPO_WAIT = 4'd11;
    localparam logic [3:0] ST_TIME_CHK = 4'd12;
    localparam logic [3:0] ST_TIME_WAIT = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [2:0] enables_reg;
    logic [31:0] ref_reg;
    logic [31:0] harm_reg;
    logic [3:0] count_reg;
    logic [1:0] mode_reg;
    logic [38:0] interval_reg;
    logic [31:0] bpm_reg;
    logic [23:0] fraction_reg;

    logic [3:0] state_reg;
    logic [39:0] t_reg;
    logic [31:0] f_reg;
    logic [31:0] best_reg;
    logic [31:0] dist_reg;
    logic [1:0] src_reg;
    logic have_reg;
    logic [7:0] n_reg;
    logic [2:0] bit_reg;
    logic [CW-1:0] idx_reg;
    logic [W-1:0] step_reg;
    logic [39:0] tout_reg;
    logic snapped_reg;
    logic m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic [2:0] m_tuser_reg;

    logic [39:0] in_time;
    logic [31:0] in_freq;
    logic [2:0] in_index;
    logic [31:0] in_entry;
    logic s_xfer;
    logic out_free;

    logic [7:0] try_n;
    logic [8:0] biased;
    logic [56:0] prod;
    logic [4:0] shift;
    logic [57:0] rounded;
    logic [31:0] cand_note;

    tfgs_pkg::div_ctl_t div_ctl;
    tfgs_pkg::div_sts_t div_sts;
    logic [W-1:0] div_num;
    logic [W-1:0] div_den;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    logic [CW-1:0] cust_lim;
    logic ram_we;
    logic [31:0] ram_rdata;

    logic [31:0] h_rem;
    logic h_up;
    logic [32:0] h_cand33;
    logic [31:0] h_cand;
    logic [31:0] h_dist;
    logic [31:0] c_dist;

    logic [39:0] mag;
    logic [W:0] t_res;
    logic [39:0] t_out;
    logic [29:0] frac60;

    assign in_time = s_tdata[39:0];
    assign in_freq = s_tdata[71:40];
    assign in_index = s_tdata[74:72];
    assign in_entry = s_tdata[106:75];

    assign s_tready = state_reg == ST_IDLE;
    assign s_xfer = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg <= 3'd0;
            ref_reg <= 32'd28835840;
            harm_reg <= 32'd0;
            count_reg <= 4'd0;
            mode_reg <= tfgs_pkg::TIMING_OFF;
            interval_reg <= 39'd0;
            bpm_reg <= 32'd7864320;
            fraction_reg <= 24'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                tfgs_pkg::REG_FREQUENCY_ENABLES: enables_reg <= cfg_data[2:0];
                tfgs_pkg::REG_REFERENCE_PITCH: ref_reg <= cfg_data[31:0];
                tfgs_pkg::REG_HARMONIC_FUNDAMENTAL: harm_reg <= cfg_data[31:0];
                tfgs_pkg::REG_CUSTOM_COUNT: count_reg <= cfg_data[3:0];
                tfgs_pkg::REG_TIMING_MODE: mode_reg <= cfg_data[1:0];
                tfgs_pkg::REG_INTERVAL_LENGTH: interval_reg <= cfg_data;
                tfgs_pkg::REG_TEMPO_BPM: bpm_reg <= cfg_data[31:0];
                tfgs_pkg::REG_BEAT_FRACTION: fraction_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign try_n = n_reg | (8'd1 << bit_reg);
    assign biased = (state_reg == ST_CAND_A) ? (9'({n_reg, 1'b0}) + 9'd6)
                                             : (9'({try_n, 1'b0}) + 9'd5);

    tfgs_scale u_scale (
        .aclk      (aclk),
        .ref_pitch (ref_reg),
        .biased    (biased),
        .prod_reg  (prod),
        .shift_reg (shift)
    );

    assign rounded = (58'(prod) + (58'd1 << (shift - 5'd1))) >> shift;
    assign cand_note = (rounded > 58'hFFFFFFFF) ? 32'hFFFFFFFF : rounded[31:0];

    assign cust_lim = (8'(count_reg) > 8'(CUSTOM_DEPTH)) ? CW'(CUSTOM_DEPTH) : CW'(count_reg);
    assign ram_we = s_xfer && (s_tuser == tfgs_pkg::OP_WRITE)
                    && (8'(in_index) < 8'(CUSTOM_DEPTH));

    tfgs_ram #(
        .WIDTH (32),
        .DEPTH (CUSTOM_DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .we        (ram_we),
        .waddr     (AW'(in_index)),
        .wdata     (in_entry),
        .raddr     (idx_reg[AW-1:0]),
        .rdata_reg (ram_rdata)
    );

    assign frac60 = 30'(fraction_reg) * 30'd60;
    assign mag = t_reg[39] ? (40'd0 - t_reg) : t_reg;

    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.iters = tfgs_pkg::ITER_W'(W);
        div_num = W'(mag) << (W - 40);
        div_den = step_reg;
        case (state_reg)
            ST_HARM_CHK: begin
                div_ctl.start = enables_reg[1] && (harm_reg != 32'd0);
                div_ctl.iters = tfgs_pkg::ITER_W'(32);
                div_num = W'(f_reg) << (W - 32);
                div_den = W'(harm_reg);
            end
            ST_TEMPO_CHK: begin
                div_ctl.start = (mode_reg == tfgs_pkg::TIMING_TEMPO) && (bpm_reg != 32'd0);
                div_ctl.iters = tfgs_pkg::ITER_W'(W);
                div_num = (W'(frac60) << FRACTION_BITS) + W'(bpm_reg >> 1);
                div_den = W'(bpm_reg);
            end
            ST_TIME_CHK: begin
                div_ctl.start = step_reg != '0;
                div_ctl.iters = tfgs_pkg::ITER_W'(40);
            end
            default: ;
        endcase
    end

    tfgs_div #(
        .W (W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quo_reg (div_quo),
        .rem_reg (div_rem)
    );

    assign h_rem = div_rem[31:0];
    assign h_up = {h_rem, 1'b0} >= {1'b0, harm_reg};
    assign h_cand33 = (f_reg < harm_reg && !h_up) ? {1'b0, harm_reg}
                    : ({1'b0, f_reg} - {1'b0, h_rem} + (h_up ? {1'b0, harm_reg} : 33'd0));
    assign h_cand = h_cand33[32] ? 32'hFFFFFFFF : h_cand33[31:0];
    assign h_dist = (h_cand > f_reg) ? h_cand - f_reg : f_reg - h_cand;
    assign c_dist = (ram_rdata > f_reg) ? ram_rdata - f_reg : f_reg - ram_rdata;

    assign t_res = (W+1)'(mag) - (W+1)'(div_rem)
                 + (({div_rem, 1'b0} >= {1'b0, step_reg}) ? (W+1)'(step_reg) : '0);
    always_comb begin
        if (t_reg[39]) begin
            t_out = (t_res > (W+1)'(40'h8000000000)) ? 40'h8000000000 : 40'd0 - t_res[39:0];
        end else begin
            t_out = (t_res > (W+1)'(40'h7FFFFFFFFF)) ? 40'h7FFFFFFFFF : t_res[39:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer && s_tuser == tfgs_pkg::OP_SNAP) begin
                        if (enables_reg[0] && ref_reg != 32'd0 && in_freq != 32'd0) begin
                            state_reg <= ST_NOTE_A;
                        end else begin
                            state_reg <= ST_HARM_CHK;
                        end
                    end
                end
                ST_NOTE_A: state_reg <= ST_NOTE_B;
                ST_NOTE_B: state_reg <= (bit_reg == 3'd0) ? ST_CAND_A : ST_NOTE_A;
                ST_CAND_A: state_reg <= ST_CAND_B;
                ST_CAND_B: state_reg <= ST_HARM_CHK;
                ST_HARM_CHK: state_reg <= div_ctl.start ? ST_HARM_WAIT : ST_CUST_CHK;
                ST_HARM_WAIT: begin
                    if (div_sts.done) begin
                        state_reg <= ST_CUST_CHK;
                    end
                end
                ST_CUST_CHK: begin
                    state_reg <= (enables_reg[2] && cust_lim != '0) ? ST_CUST_RD : ST_TEMPO_CHK;
                end
                ST_CUST_RD: state_reg <= ST_CUST_CMP;
                ST_CUST_CMP: begin
                    state_reg <= (idx_reg + 1'b1 < cust_lim) ? ST_CUST_RD : ST_TEMPO_CHK;
                end
                ST_TEMPO_CHK: state_reg <= div_ctl.start ? ST_TEMPO_WAIT : ST_TIME_CHK;
                ST_TEMPO_WAIT: begin
                    if (div_sts.done) begin
                        state_reg <= ST_TIME_CHK;
                    end
                end
                ST_TIME_CHK: state_reg <= div_ctl.start ? ST_TIME_WAIT : ST_DONE;
                ST_TIME_WAIT: begin
                    if (div_sts.done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                t_reg <= in_time;
                f_reg <= in_freq;
                best_reg <= in_freq;
                dist_reg <= 32'd0;
                src_reg <= tfgs_pkg::SRC_NONE;
                have_reg <= 1'b0;
                n_reg <= 8'(tfgs_pkg::NOTE_LOW);
                bit_reg <= 3'd7;
                idx_reg <= '0;
                step_reg <= '0;
            end
            ST_NOTE_B: begin
                if (try_n <= 8'(NOTE_HIGH) && rounded <= 58'(f_reg)) begin
                    n_reg <= try_n;
                end
                bit_reg <= bit_reg - 3'd1;
            end
            ST_CAND_B: begin
                best_reg <= cand_note;
                dist_reg <= (cand_note > f_reg) ? cand_note - f_reg : f_reg - cand_note;
                src_reg <= tfgs_pkg::SRC_NOTE;
                have_reg <= 1'b1;
            end
            ST_HARM_WAIT: begin
                if (div_sts.done && (!have_reg || h_dist < dist_reg)) begin
                    best_reg <= h_cand;
                    dist_reg <= h_dist;
                    src_reg <= tfgs_pkg::SRC_HARMONIC;
                    have_reg <= 1'b1;
                end
            end
            ST_CUST_CMP: begin
                if (!have_reg || c_dist < dist_reg) begin
                    best_reg <= ram_rdata;
                    dist_reg <= c_dist;
                    src_reg <= tfgs_pkg::SRC_CUSTOM;
                    have_reg <= 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            ST_TEMPO_CHK: begin
                if (mode_reg == tfgs_pkg::TIMING_INTERVAL) begin
                    step_reg <= W'(interval_reg);
                end
            end
            ST_TEMPO_WAIT: begin
                if (div_sts.done) begin
                    step_reg <= div_quo;
                end
            end
            ST_TIME_CHK: begin
                tout_reg <= t_reg;
                snapped_reg <= 1'b0;
            end
            ST_TIME_WAIT: begin
                if (div_sts.done) begin
                    tout_reg <= t_out;
                    snapped_reg <= 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {best_reg, tout_reg};
                    m_tuser_reg <= {snapped_reg, src_reg};
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_unchanged_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (m_tuser[1:0] != tfgs_pkg::SRC_NONE || m_tdata[71:40] == f_reg))
        else $error("frequency changed without a source");
    a_unchanged_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tuser[2] || m_tdata[39:0] == t_reg))
        else $error("time changed without a snap");
    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CAND_B |-> n_reg <= 8'(NOTE_HIGH))
        else $error("note index beyond range");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.busy |-> !s_tready)
        else $error("input taken while a division runs");
`endif

endmodule
`default_nettype wire

/* src/tfgs_ram.sv */
`default_nettype none
module tfgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]               wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic      [WIDTH-1:0]               rdata_reg
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

/* src/tfgs_div.sv */
`default_nettype none
module tfgs_div #(
    parameter int W = 48
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tfgs_pkg::div_ctl_t ctl,
    input  wire logic [W-1:0]     num,
    input  wire logic [W-1:0]     den,
    output tfgs_pkg::div_sts_t    sts,
    output logic      [W-1:0]     quo_reg,
    output logic      [W-1:0]     rem_reg
);

    logic [W-1:0] num_reg;
    logic [W-1:0] den_reg;
    logic [tfgs_pkg::ITER_W-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [W:0] trial;
    logic ge;

    assign trial = {rem_reg, num_reg[W-1]};
    assign ge = trial >= {1'b0, den_reg};
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= ctl.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tfgs_pkg::ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg <= '0;
            quo_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
            num_reg <= num_reg << 1;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

/* src/tfgs_scale.sv */
`default_nettype none
module tfgs_scale (
    input  wire logic        aclk,
    input  wire logic [31:0] ref_pitch,
    input  wire logic [8:0]  biased,
    output logic      [56:0] prod_reg,
    output logic      [4:0]  shift_reg
);

    logic [16:0] recip;
    logic [4:0] octave;
    logic [8:0] rem9;
    logic [4:0] idx;

    assign recip = 17'(biased) * 17'd171;
    assign octave = recip[16:12];
    assign rem9 = biased - (9'(octave) * 9'd24);
    assign idx = rem9[4:0];

    always_ff @(posedge aclk) begin
        prod_reg <= 57'(ref_pitch) * 57'(tfgs_pkg::pow24(idx));
        shift_reg <= 5'd30 - octave;
    end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int TABLE_DEPTH = 8;
    localparam int PHASES = 20;
    localparam int ITEMS_PER_PHASE = 92;

    typedef struct {
        logic        op;
        logic [39:0] time_value;
        logic [31:0] frequency_value;
        logic [2:0]  entry_index;
        logic [31:0] entry_frequency;
    } grid_request_t;

    typedef struct {
        logic [39:0] time_out;
        logic [31:0] frequency_out;
        logic [1:0]  frequency_source;
        logic        time_snapped;
    } grid_point_t;

    class grid_scoreboard;
        logic [63:0] ratio_q24 [24];
        logic [2:0]  enables;
        logic [31:0] pitch_ref;
        logic [31:0] fundamental;
        logic [3:0]  entry_count;
        logic [1:0]  timing;
        logic [38:0] interval;
        logic [31:0] bpm;
        logic [23:0] fraction;
        logic [31:0] entry_table [TABLE_DEPTH];
        grid_point_t pending_points [$];
        int          errors;

        function new();
            ratio_q24 = '{64'd16777216, 64'd17268826, 64'd17774841, 64'd18295684,
                          64'd18831788, 64'd19383602, 64'd19951585, 64'd20536211,
                          64'd21137968, 64'd21757357, 64'd22394897, 64'd23051117,
                          64'd23726566, 64'd24421808, 64'd25137421, 64'd25874004,
                          64'd26632170, 64'd27412552, 64'd28215802, 64'd29042588,
                          64'd29893600, 64'd30769550, 64'd31671166, 64'd32599202};
            enables = 3'd0;
            pitch_ref = 32'd28835840;
            fundamental = 32'd0;
            entry_count = 4'd0;
            timing = tfgs_pkg::TIMING_OFF;
            interval = 39'd0;
            bpm = 32'd7864320;
            fraction = 24'd65536;
            foreach (entry_table[i]) entry_table[i] = 32'd0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_register(logic [3:0] index, logic [38:0] value);
            case (index)
                tfgs_pkg::REG_FREQUENCY_ENABLES: enables = value[2:0];
                tfgs_pkg::REG_REFERENCE_PITCH: pitch_ref = value[31:0];
                tfgs_pkg::REG_HARMONIC_FUNDAMENTAL: fundamental = value[31:0];
                tfgs_pkg::REG_CUSTOM_COUNT: entry_count = value[3:0];
                tfgs_pkg::REG_TIMING_MODE: timing = value[1:0];
                tfgs_pkg::REG_INTERVAL_LENGTH: interval = value;
                tfgs_pkg::REG_TEMPO_BPM: bpm = value[31:0];
                tfgs_pkg::REG_BEAT_FRACTION: fraction = value[23:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] pitch_power(logic [63:0] base, int e);
            int biased;
            int shift;
            logic [63:0] p;
            biased = e + 144;
            shift = 24 - (biased / 24 - 6);
            p = base * ratio_q24[biased % 24];
            return (p + (64'd1 << (shift - 1))) >> shift;
        endfunction

        function logic [63:0] distance(logic [63:0] a, logic [63:0] b);
            return a > b ? a - b : b - a;
        endfunction

        function void note_input(grid_request_t req);
            logic [63:0] f, best, best_dist, cand, d, m, mag, step, tout;
            logic [1:0]  src;
            logic        have, neg;
            int          n, cnt;
            grid_point_t pt;
            if (req.op == tfgs_pkg::OP_WRITE) begin
                entry_table[req.entry_index] = req.entry_frequency;
                return;
            end
            f = {32'd0, req.frequency_value};
            best = f;
            best_dist = 0;
            src = tfgs_pkg::SRC_NONE;
            have = 1'b0;
            if (enables[0] && pitch_ref != 0 && f != 0) begin
                n = tfgs_pkg::NOTE_LOW;
                for (int k = tfgs_pkg::NOTE_LOW + 1; k <= 135; k++)
                    if (f >= pitch_power({32'd0, pitch_ref}, 2 * k - 139)) n = k;
                cand = pitch_power({32'd0, pitch_ref}, 2 * n - 138);
                if (cand > 64'hFFFF_FFFF) cand = 64'hFFFF_FFFF;
                best = cand;
                best_dist = distance(cand, f);
                src = tfgs_pkg::SRC_NOTE;
                have = 1'b1;
            end
            if (enables[1] && fundamental != 0) begin
                m = (2 * f + fundamental) / (2 * {32'd0, fundamental});
                if (m < 1) m = 1;
                cand = m * fundamental;
                if (cand > 64'hFFFF_FFFF) cand = 64'hFFFF_FFFF;
                d = distance(cand, f);
                if (!have || d < best_dist) begin
                    best = cand;
                    best_dist = d;
                    src = tfgs_pkg::SRC_HARMONIC;
                    have = 1'b1;
                end
            end
            if (enables[2]) begin
                cnt = entry_count > TABLE_DEPTH ? TABLE_DEPTH : entry_count;
                for (int i = 0; i < cnt; i++) begin
                    d = distance({32'd0, entry_table[i]}, f);
                    if (!have || d < best_dist) begin
                        best = entry_table[i];
                        best_dist = d;
                        src = tfgs_pkg::SRC_CUSTOM;
                        have = 1'b1;
                    end
                end
            end
            neg = req.time_value[39];
            mag = neg ? (((64'd1 << 40) - req.time_value) & 64'hFF_FFFF_FFFF)
                      : {24'd0, req.time_value};
            if (neg && mag == 0) mag = 64'h80_0000_0000;
            step = 0;
            if (timing == tfgs_pkg::TIMING_INTERVAL) begin
                step = interval;
            end else if (timing == tfgs_pkg::TIMING_TEMPO && bpm != 0) begin
                step = (((64'd60 * fraction) << 16) + bpm / 2) / bpm;
            end
            pt.time_snapped = 1'b0;
            if (step != 0) begin
                mag = ((2 * mag + step) / (2 * step)) * step;
                pt.time_snapped = 1'b1;
            end
            if (neg) begin
                if (mag > 64'h80_0000_0000) mag = 64'h80_0000_0000;
                tout = ((64'd1 << 40) - mag) & 64'hFF_FFFF_FFFF;
            end else begin
                if (mag > 64'h7F_FFFF_FFFF) mag = 64'h7F_FFFF_FFFF;
                tout = mag;
            end
            pt.time_out = tout[39:0];
            pt.frequency_out = best[31:0];
            pt.frequency_source = src;
            pending_points = {pending_points, pt};
        endfunction

        task check(grid_point_t got);
            grid_point_t want;
            if (pending_points.size() == 0) begin
                report("result transfer with nothing pending");
                return;
            end
            want = pending_points.pop_front();
            if (got.time_out !== want.time_out)
                report($sformatf("time_out %h, wanted %h", got.time_out, want.time_out));
            if (got.frequency_out !== want.frequency_out)
                report($sformatf("frequency_out %h, wanted %h",
                                 got.frequency_out, want.frequency_out));
            if (got.frequency_source !== want.frequency_source)
                report($sformatf("frequency_source %0d, wanted %0d",
                                 got.frequency_source, want.frequency_source));
            if (got.time_snapped !== want.time_snapped)
                report($sformatf("time_snapped %0d, wanted %0d",
                                 got.time_snapped, want.time_snapped));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [38:0]  cfg_data = '0;

    grid_scoreboard snap_board = new();
    int burst_left = 0;
    int idle_count = 0;
    int ready_mode = 0;
    int ready_timer = 0;

    time_frequency_grid_snap_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        grid_point_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.time_out = m_tdata[39:0];
            got.frequency_out = m_tdata[71:40];
            got.frequency_source = m_tuser[1:0];
            got.time_snapped = m_tuser[2];
            snap_board.check(got);
        end
        if (ready_timer == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_timer = $urandom_range(50, 800);
        end else begin
            ready_timer--;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (ready_timer % 16) < 5;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic write_register(logic [3:0] index, logic [38:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        snap_board.set_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(grid_request_t req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                              : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= req.op;
        s_tdata <= {5'd0, req.entry_frequency, req.entry_index,
                    req.frequency_value, req.time_value};
        do @(posedge aclk); while (!s_tready);
        snap_board.note_input(req);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (snap_board.pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic snap_point(logic [39:0] t, logic [31:0] f);
        grid_request_t req;
        req.op = tfgs_pkg::OP_SNAP;
        req.time_value = t;
        req.frequency_value = f;
        req.entry_index = 3'($urandom);
        req.entry_frequency = $urandom;
        send_request(req);
    endtask

    task automatic table_write(logic [2:0] index, logic [31:0] f);
        grid_request_t req;
        req.op = tfgs_pkg::OP_WRITE;
        req.time_value = 40'({$urandom, $urandom});
        req.frequency_value = $urandom;
        req.entry_index = index;
        req.entry_frequency = f;
        send_request(req);
    endtask

    function automatic logic [31:0] pick_frequency();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 3);
            default: return ($urandom_range(16, 20000) << 16) | $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [39:0] pick_time();
        logic [39:0] t;
        case ($urandom_range(0, 5))
            0: t = 40'({$urandom, $urandom});
            1: t = $urandom_range(0, 1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
            default: begin
                t = {8'd0, $urandom} >> $urandom_range(0, 12);
                if ($urandom_range(0, 1)) t = -t;
            end
        endcase
        return t;
    endfunction

    task automatic random_settings();
        logic [38:0] v;
        write_register(tfgs_pkg::REG_FREQUENCY_ENABLES, 39'($urandom_range(0, 7)));
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom;
            default: v = $urandom_range(400 << 16, 480 << 16);
        endcase
        write_register(tfgs_pkg::REG_REFERENCE_PITCH, v);
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom_range(1, 255);
            default: v = $urandom_range(20 << 16, 500 << 16);
        endcase
        write_register(tfgs_pkg::REG_HARMONIC_FUNDAMENTAL, v);
        write_register(tfgs_pkg::REG_CUSTOM_COUNT, 39'($urandom_range(0, 15)));
        write_register(tfgs_pkg::REG_TIMING_MODE, 39'($urandom_range(0, 3)));
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 39'h7F_FFFF_FFFF;
            2: v = 39'({$urandom, $urandom});
            default: v = $urandom_range(1, 1 << 18);
        endcase
        write_register(tfgs_pkg::REG_INTERVAL_LENGTH, v);
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom;
            default: v = $urandom_range(40 << 16, 240 << 16);
        endcase
        write_register(tfgs_pkg::REG_TEMPO_BPM, v);
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 24'hFF_FFFF;
            2: v = $urandom;
            default: v = $urandom_range(1 << 14, 4 << 16);
        endcase
        write_register(tfgs_pkg::REG_BEAT_FRACTION, v);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < TABLE_DEPTH; i++)
            table_write(3'(i), i == 0 ? 32'd0 : i == 7 ? 32'hFFFF_FFFF : pick_frequency());
        snap_point(40'd65536, 32'd440 << 16);
        wait_idle();
        write_register(tfgs_pkg::REG_FREQUENCY_ENABLES, 39'd7);
        write_register(tfgs_pkg::REG_REFERENCE_PITCH, 39'd440 << 16);
        write_register(tfgs_pkg::REG_HARMONIC_FUNDAMENTAL, 39'd110 << 16);
        write_register(tfgs_pkg::REG_CUSTOM_COUNT, 39'd8);
        write_register(tfgs_pkg::REG_TIMING_MODE, 39'(tfgs_pkg::TIMING_INTERVAL));
        write_register(tfgs_pkg::REG_INTERVAL_LENGTH, 39'd65536);
        write_register(4'd9, 39'h12345);
        snap_point(40'd0, 32'd0);
        snap_point(40'd32768, 32'hFFFF_FFFF);
        snap_point(-40'sd32768, 32'd1);
        snap_point(40'h7F_FFFF_FFFF, 32'd440 << 16);
        snap_point(40'h80_0000_0000, 32'd220 << 16);
        snap_point(-40'sd1, 32'd330 << 16);
        table_write(3'd2, 32'd1000 << 16);
        snap_point(40'd98304, 32'd999 << 16);
        wait_idle();
        write_register(tfgs_pkg::REG_TIMING_MODE, 39'(tfgs_pkg::TIMING_TEMPO));
        write_register(tfgs_pkg::REG_TEMPO_BPM, 39'd0);
        write_register(tfgs_pkg::REG_CUSTOM_COUNT, 39'd15);
        snap_point(40'd123456, 32'd5 << 16);
        wait_idle();
        write_register(tfgs_pkg::REG_TEMPO_BPM, 39'd120 << 16);
        write_register(tfgs_pkg::REG_BEAT_FRACTION, 39'hFF_FFFF);
        write_register(tfgs_pkg::REG_FREQUENCY_ENABLES, 39'd2);
        snap_point(40'h7F_0000_0000, 32'd0);
        snap_point(-40'sd65536, 32'd50 << 16);
        wait_idle();
        write_register(tfgs_pkg::REG_TIMING_MODE, 39'd3);
        write_register(tfgs_pkg::REG_FREQUENCY_ENABLES, 39'd0);
        snap_point(40'd777, 32'd12345);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            random_settings();
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(0, 9) < 7) snap_point(pick_time(), pick_frequency());
                else table_write(3'($urandom), pick_frequency());
            end
            wait_idle();
        end

        if (snap_board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
